// File: sv/ite_pkg.sv
`timescale 1ns / 1ps

package ite_pkg;

    localparam int PAYLOAD_BUFFER_BYTES = 256;

    localparam int LIMIT_W    = 9;
    localparam int POS_W      = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 144;
    localparam int KIND_W     = 3;
    localparam int IFN_W      = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_NOT_TCP = 2'd1;
    localparam logic [1:0] STATUS_FRAG    = 2'd2;
    localparam logic [1:0] STATUS_TRUNC   = 2'd3;

    localparam logic ITEM_PAYLOAD = 1'b0;
    localparam logic ITEM_RECORD  = 1'b1;

    localparam logic [7:0]  TCP_PROTOCOL     = 8'd6;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [15:0] FRAG_MASK        = 16'h2000 | 16'h1FFF;
    localparam logic [6:0]  ETH_HEADER_BYTES = 7'd14;
    localparam logic [3:0]  MIN_HDR_WORDS    = 4'd5;
    localparam logic [7:0]  IHL_MASK         = 8'h0f;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_value;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol_number;
        logic [2:0]  record_kind;
        logic [15:0] record_interface;
        logic [8:0]  payload_count;
        logic [1:0]  status;
    } t_result;

endpackage

// File: sv/ipv4_tcp_header_extractor.sv
`timescale 1ns / 1ps
// Ethernet IPv4/TCP header extractor.
// Frame bytes enter on the s_axis channel, one item per byte starting at the
// destination MAC, with tlast on the final byte of the frame. Each payload
// byte of a good TCP frame leaves on m_axis with tuser 0, up to the limit set
// through the configuration channel. The final byte of an IPv4 frame yields one
// record with tuser 1 carrying the status and protocol, and for a good status also
// the addresses, ports and clamped payload length. Frames of other ethertypes give
// no output. The configuration channel is always ready; the user must write it
// only between frames, as the block does not enforce it. An accepted byte passes
// an input register and then the result register before its output item is offered.
// One byte is accepted in every cycle while m_axis takes its items; the rate is
// set by the single input register stage feeding the result register. When m_axis
// stalls, the result register holds and the input register fills, after which
// s_axis_tready drops until the result is taken. Reset empties both registers,
// clears all per-frame header state and sets the payload limit to 256 bytes.

module ipv4_tcp_header_extractor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_byte [7:0], interface_number [23:8]
    input  logic [ite_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tlast,
    // packet_kind [2:0]
    input  logic [ite_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // payload_value [7:0], source_address [39:8], dest_address [71:40],
    // source_port [87:72], dest_port [103:88], protocol_number [111:104],
    // record_kind [114:112], record_interface [130:115],
    // payload_count [139:131], status [141:140], zero fill [143:142]
    output logic [ite_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // item_kind [0]
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ite_pkg::LIMIT_W-1:0]         i_cfg_data
);

    logic [ite_pkg::LIMIT_W-1:0] r_limit;
    logic                        r_s1_valid;
    logic [7:0]                  r_s1_byte;
    logic                        r_s1_end;
    logic [ite_pkg::KIND_W-1:0]  r_s1_kind;
    logic [ite_pkg::IFN_W-1:0]   r_s1_ifn;
    logic                        r_out_valid;
    ite_pkg::t_result            r_out;

    logic                        advance;
    logic                        res_valid;
    ite_pkg::t_result            res;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ite_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_byte <= s_axis_tdata[7:0];
            r_s1_ifn  <= s_axis_tdata[23:8];
            r_s1_end  <= s_axis_tlast;
            r_s1_kind <= s_axis_tuser;
        end
    end

    ite_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_s1_byte),
        .i_end       (r_s1_end),
        .i_kind      (r_s1_kind),
        .i_ifn       (r_s1_ifn),
        .i_limit     (r_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.item_kind;
    assign m_axis_tdata  = {2'b00, r_out.status, r_out.payload_count, r_out.record_interface,
                            r_out.record_kind, r_out.protocol_number, r_out.dest_port,
                            r_out.source_port, r_out.dest_address, r_out.source_address,
                            r_out.payload_value};

endmodule

// File: sv/ite_parse.sv
`timescale 1ns / 1ps

module ite_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [7:0]                   i_byte,
    input  logic                         i_end,
    input  logic [ite_pkg::KIND_W-1:0]   i_kind,
    input  logic [ite_pkg::IFN_W-1:0]    i_ifn,
    input  logic [ite_pkg::LIMIT_W-1:0]  i_limit,
    output logic                         o_res_valid,
    output ite_pkg::t_result             o_res
);

    localparam logic [15:0] POS_ETH_HI   = 16'd12;
    localparam logic [15:0] POS_ETH_LO   = 16'd13;
    localparam logic [15:0] POS_IHL      = 16'd14;
    localparam logic [15:0] POS_LEN_HI   = 16'd16;
    localparam logic [15:0] POS_LEN_LO   = 16'd17;
    localparam logic [15:0] POS_FRAG_HI  = 16'd20;
    localparam logic [15:0] POS_FRAG_LO  = 16'd21;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_PAY_MIN  = 16'd24;
    localparam logic [15:0] POS_ADDR_LO  = 16'd26;
    localparam logic [15:0] POS_ADDR_HI  = 16'd33;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [15:0] DOFF_OFFSET  = 16'd12;

    logic [ite_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_eth, n_eth;
    logic [3:0]                r_ihl, n_ihl;
    logic [3:0]                r_doff, n_doff;
    logic [15:0]               r_total, n_total;
    logic [15:0]               r_frag, n_frag;
    logic [7:0]                r_proto, n_proto;
    logic [7:0]                r_addr [8];
    logic [7:0]                n_addr [8];
    logic [7:0]                r_port [4];
    logic [7:0]                n_port [4];
    logic [8:0]                r_sent, n_sent;

    logic [3:0]  eff_ihl, eff_doff;
    logic [5:0]  ihl_bytes, doff_bytes;
    logic [6:0]  tcp_start;
    logic [7:0]  pay_start;
    logic [6:0]  hdr_bytes;
    logic [15:0] pay_len;
    logic [8:0]  cap;
    logic [8:0]  target;
    logic [15:0] addr_off, port_off;
    logic        frag_bad;
    logic        pay_ok;
    logic        rec_ok;
    logic [1:0]  status;

    always_comb begin
        eff_ihl    = (r_ihl < ite_pkg::MIN_HDR_WORDS) ? ite_pkg::MIN_HDR_WORDS : r_ihl;
        eff_doff   = (r_doff < ite_pkg::MIN_HDR_WORDS) ? ite_pkg::MIN_HDR_WORDS : r_doff;
        ihl_bytes  = {eff_ihl, 2'b00};
        doff_bytes = {eff_doff, 2'b00};
        tcp_start  = ite_pkg::ETH_HEADER_BYTES + {1'b0, ihl_bytes};
        pay_start  = {1'b0, tcp_start} + {2'b00, doff_bytes};
        hdr_bytes  = {1'b0, ihl_bytes} + {1'b0, doff_bytes};
        pay_len    = (r_total > {9'd0, hdr_bytes}) ? (r_total - {9'd0, hdr_bytes}) : 16'd0;
        if (32'(i_limit) > 32'(ite_pkg::PAYLOAD_BUFFER_BYTES)) begin
            cap = 9'(ite_pkg::PAYLOAD_BUFFER_BYTES);
        end else begin
            cap = i_limit;
        end
        target   = (pay_len < {7'd0, cap}) ? pay_len[8:0] : cap;
        frag_bad = |(r_frag & ite_pkg::FRAG_MASK);
        addr_off = r_pos - POS_ADDR_LO;
        port_off = r_pos - {9'd0, tcp_start};
    end

    always_comb begin
        n_eth   = r_eth;
        n_ihl   = r_ihl;
        n_doff  = r_doff;
        n_total = r_total;
        n_frag  = r_frag;
        n_proto = r_proto;
        n_addr  = r_addr;
        n_port  = r_port;
        if (r_pos == POS_ETH_HI) begin
            n_eth = (i_byte == ite_pkg::ETHERTYPE_IPV4[15:8]);
        end else if (r_pos == POS_ETH_LO) begin
            n_eth = r_eth && (i_byte == ite_pkg::ETHERTYPE_IPV4[7:0]);
        end else if (r_pos == POS_IHL) begin
            n_ihl = 4'(i_byte & ite_pkg::IHL_MASK);
        end else if (r_pos == POS_LEN_HI) begin
            n_total[15:8] = i_byte;
        end else if (r_pos == POS_LEN_LO) begin
            n_total[7:0] = i_byte;
        end else if (r_pos == POS_FRAG_HI) begin
            n_frag[15:8] = i_byte;
        end else if (r_pos == POS_FRAG_LO) begin
            n_frag[7:0] = i_byte;
        end else if (r_pos == POS_PROTO) begin
            n_proto = i_byte;
        end else if (r_pos >= POS_ADDR_LO && r_pos <= POS_ADDR_HI) begin
            n_addr[addr_off[2:0]] = i_byte;
        end
        if (r_pos >= {9'd0, tcp_start} && r_pos < {9'd0, tcp_start} + 16'd4) begin
            n_port[port_off[1:0]] = i_byte;
        end else if (r_pos == {9'd0, tcp_start} + DOFF_OFFSET) begin
            n_doff = i_byte[7:4];
        end
    end

    always_comb begin
        pay_ok = !i_end && r_eth && (r_pos >= POS_PAY_MIN) && (r_proto == ite_pkg::TCP_PROTOCOL)
                 && !frag_bad && (r_pos >= {8'd0, pay_start}) && (r_sent < target);
        rec_ok = i_end && (r_pos >= POS_ETH_LO) && n_eth;
        if (r_pos < POS_PROTO) begin
            status = ite_pkg::STATUS_TRUNC;
        end else if (n_proto != ite_pkg::TCP_PROTOCOL) begin
            status = ite_pkg::STATUS_NOT_TCP;
        end else if (frag_bad) begin
            status = ite_pkg::STATUS_FRAG;
        end else if (r_pos < {8'd0, pay_start} || r_sent < target) begin
            status = ite_pkg::STATUS_TRUNC;
        end else begin
            status = ite_pkg::STATUS_GOOD;
        end

        o_res       = '0;
        o_res_valid = pay_ok || rec_ok;
        if (rec_ok) begin
            o_res.item_kind        = ite_pkg::ITEM_RECORD;
            o_res.protocol_number  = n_proto;
            o_res.record_kind      = i_kind;
            o_res.record_interface = i_ifn;
            o_res.status           = status;
            if (status == ite_pkg::STATUS_GOOD) begin
                o_res.source_address = {r_addr[0], r_addr[1], r_addr[2], r_addr[3]};
                o_res.dest_address   = {r_addr[4], r_addr[5], r_addr[6], r_addr[7]};
                o_res.source_port    = {r_port[0], r_port[1]};
                o_res.dest_port      = {r_port[2], r_port[3]};
                o_res.payload_count  = target;
            end
        end else begin
            o_res.item_kind     = ite_pkg::ITEM_PAYLOAD;
            o_res.payload_value = i_byte;
        end

        n_sent = pay_ok ? (r_sent + 9'd1) : r_sent;
        n_pos  = (r_pos < POS_MAX) ? (r_pos + 16'd1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_end)) begin
            r_pos   <= '0;
            r_eth   <= 1'b0;
            r_ihl   <= '0;
            r_doff  <= '0;
            r_total <= '0;
            r_frag  <= '0;
            r_proto <= '0;
            r_addr  <= '{default: '0};
            r_port  <= '{default: '0};
            r_sent  <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_eth   <= n_eth;
            r_ihl   <= n_ihl;
            r_doff  <= n_doff;
            r_total <= n_total;
            r_frag  <= n_frag;
            r_proto <= n_proto;
            r_addr  <= n_addr;
            r_port  <= n_port;
            r_sent  <= n_sent;
        end
    end

endmodule

// File: sv/ite_checker.sv
`timescale 1ns / 1ps

module ite_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ite_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output item changed.");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ite_pkg::ITEM_PAYLOAD) |-> m_axis_tdata[143:8] == '0)
        else $error("Payload item carries record fields.");

    a_bad_record_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ite_pkg::ITEM_RECORD)
        && (m_axis_tdata[141:140] != ite_pkg::STATUS_GOOD)
        |-> m_axis_tdata[103:0] == '0 && m_axis_tdata[139:131] == '0)
        else $error("Failed record carries header fields.");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
        else $error("Input item refused while the output is empty.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("Output valid right after reset.");

endmodule

bind ipv4_tcp_header_extractor ite_checker u_ite_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
